@@ sv/vdb_pkg.sv @@
`default_nettype none
package vdb_pkg;
   localparam int unsigned FloatWidth = 32;
   localparam int unsigned IndexWidth = 8;

   typedef logic [FloatWidth-1:0] float_type;

   typedef struct packed {
      float_type x;
      float_type y;
      float_type z;
   } vec_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   function automatic logic f_nan(input float_type a);
      return a[30:0] > 31'h7F800000;
   endfunction

   function automatic logic f_eq(input float_type a, input float_type b);
      if (f_nan(a) || f_nan(b)) return 1'b0;
      if (((a | b) & 32'h7FFFFFFF) == 32'h0) return 1'b1;
      return a == b;
   endfunction

   function automatic logic f_lt(input float_type a, input float_type b);
      if (f_nan(a) || f_nan(b)) return 1'b0;
      if (((a | b) & 32'h7FFFFFFF) == 32'h0) return 1'b0;
      if (a[31] && !b[31]) return 1'b1;
      if (!a[31] && b[31]) return 1'b0;
      if (!a[31]) return a < b;
      return a > b;
   endfunction
endpackage
`default_nettype wire

@@ sv/vdb_cell.sv @@
`default_nettype none
// One table slot. The key is held on the shared search bus; the cell reports
// a match, and on an append it loads the word when its left neighbor is valid and it is not.
module vdb_cell (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            valid_prev,
   input  wire logic            load,
   input  wire vdb_pkg::vec_type key,
   output logic                 valid,
   output logic                 hit
);
   vdb_pkg::vec_type data_ff;
   logic valid_ff, valid_in;

   assign valid_in = valid_ff | (load & valid_prev);
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (load && valid_prev && !valid_ff) data_ff <= key;
   end
   assign valid = valid_ff;
   assign hit = valid_ff && vdb_pkg::f_eq(data_ff.x, key.x)
      && vdb_pkg::f_eq(data_ff.y, key.y) && vdb_pkg::f_eq(data_ff.z, key.z);
endmodule
`default_nettype wire

@@ sv/vdb_prio.sv @@
`default_nettype none
// Lowest-index match over the cell row, as a priority scan from the top index down.
module vdb_prio #(
   parameter int unsigned N = 256,
   parameter int unsigned W = 8
) (
   input  wire logic [N-1:0] hits,
   output logic             any,
   output logic [W-1:0]     index
);
   always_comb begin
      any = 1'b0;
      index = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (hits[i]) begin
            any = 1'b1;
            index = W'(i);
         end
      end
   end
endmodule
`default_nettype wire

@@ sv/vertex_dedup_with_bounds.sv @@
`default_nettype none
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_vertex_x/y/z
// rsp       out        rsp_valid, rsp_ready, rsp_vertex_index .. rsp_box_max_z
//
// Each word is latched on accept; then, in the look state, every cell
// compares against it at once, the lowest hit is picked, and an append plus
// the box update land. The result then sits in an output register until
// taken; a new word is accepted in the same cycle that the result leaves.
// Synchronous reset empties every cell's valid bit and zeroes the box.
module vertex_dedup_with_bounds #(
   parameter int unsigned CAPACITY = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_vertex_x,
   input  wire logic [31:0] req_vertex_y,
   input  wire logic [31:0] req_vertex_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_vertex_index,
   output logic             rsp_was_new,
   output logic             rsp_table_full,
   output logic [31:0]      rsp_box_min_x,
   output logic [31:0]      rsp_box_min_y,
   output logic [31:0]      rsp_box_min_z,
   output logic [31:0]      rsp_box_max_x,
   output logic [31:0]      rsp_box_max_y,
   output logic [31:0]      rsp_box_max_z
);
   localparam int unsigned IW = $clog2(CAPACITY);

   vdb_pkg::state_type state_ff, state_in;
   vdb_pkg::vec_type   key_ff, lo_ff, hi_ff, lo_in, hi_in;
   logic [CAPACITY-1:0] hits, valids;
   logic any;
   logic [IW-1:0] hidx;
   logic [IW:0] count_ff, count_in;
   logic [7:0] idx_ff;
   logic new_ff, full_ff;
   logic append;

   assign req_ready = (state_ff == vdb_pkg::ST_IDLE)
      || (state_ff == vdb_pkg::ST_SEND && rsp_ready);

   // The append walks along the row: a cell loads when its left neighbor
   // is already valid and it is not.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      vdb_cell u_cell (
         .clock(clock), .reset(reset),
         .valid_prev(i == 0 ? 1'b1 : valids[(i == 0) ? 0 : i - 1]),
         .load(append), .key(key_ff),
         .valid(valids[i]), .hit(hits[i])
      );
   end

   vdb_prio #(.N(CAPACITY), .W(IW)) u_prio (.hits(hits), .any(any), .index(hidx));

   assign append = (state_ff == vdb_pkg::ST_LOOK) && !any
      && (count_ff < (IW+1)'(CAPACITY));

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      count_in = count_ff;
      if (append) begin
         count_in = count_ff + 1'b1;
         if (count_ff == '0) begin
            lo_in = key_ff;
            hi_in = key_ff;
         end else begin
            if (vdb_pkg::f_lt(key_ff.x, lo_ff.x)) lo_in.x = key_ff.x;
            if (vdb_pkg::f_lt(key_ff.y, lo_ff.y)) lo_in.y = key_ff.y;
            if (vdb_pkg::f_lt(key_ff.z, lo_ff.z)) lo_in.z = key_ff.z;
            if (vdb_pkg::f_lt(hi_ff.x, key_ff.x)) hi_in.x = key_ff.x;
            if (vdb_pkg::f_lt(hi_ff.y, key_ff.y)) hi_in.y = key_ff.y;
            if (vdb_pkg::f_lt(hi_ff.z, key_ff.z)) hi_in.z = key_ff.z;
         end
      end
      state_in = state_ff;
      unique case (state_ff)
         vdb_pkg::ST_IDLE: if (req_valid) state_in = vdb_pkg::ST_LOOK;
         vdb_pkg::ST_LOOK: state_in = vdb_pkg::ST_SEND;
         vdb_pkg::ST_SEND: if (rsp_ready) state_in = req_valid ? vdb_pkg::ST_LOOK
                                                               : vdb_pkg::ST_IDLE;
         default: state_in = vdb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vdb_pkg::ST_IDLE;
         count_ff <= '0;
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (req_valid && req_ready) key_ff <= {req_vertex_x, req_vertex_y, req_vertex_z};
      if (state_ff == vdb_pkg::ST_LOOK) begin
         new_ff <= append;
         full_ff <= !any && !append;
         if (any) idx_ff <= 8'(32'(hidx));
         else if (append) idx_ff <= 8'(32'(count_ff));
         else idx_ff <= 8'd0;
      end
   end

   assign rsp_valid = (state_ff == vdb_pkg::ST_SEND);
   assign rsp_vertex_index = idx_ff;
   assign rsp_was_new = new_ff;
   assign rsp_table_full = full_ff;
   assign rsp_box_min_x = lo_ff.x;
   assign rsp_box_min_y = lo_ff.y;
   assign rsp_box_min_z = lo_ff.z;
   assign rsp_box_max_x = hi_ff.x;
   assign rsp_box_max_y = hi_ff.y;
   assign rsp_box_max_z = hi_ff.z;
endmodule
`default_nettype wire

@@ dv/vertex_dedup_with_bounds_tb.sv @@
`timescale 1ns / 100ps

// Scoreboard that mirrors the vertex table and bounding box, and keeps the
// responses still owed by the block.
class dedup_scoreboard;
   typedef struct {
      logic [7:0]  index;
      logic        was_new;
      logic        full;
      logic [31:0] lo [3];
      logic [31:0] hi [3];
   } lookup_result;

   logic [31:0]  cells [256][3];
   int unsigned  fill;
   logic [31:0]  box_lo [3];
   logic [31:0]  box_hi [3];
   lookup_result owed [$];
   int unsigned  errors;

   function void clear();
      fill = 0;
      for (int a = 0; a < 3; a++) begin
         box_lo[a] = '0;
         box_hi[a] = '0;
      end
      owed.delete();
      errors = 0;
   endfunction

   function bit is_nan(logic [31:0] v);
      return v[30:0] > 31'h7F800000;
   endfunction

   function bit same(logic [31:0] p, logic [31:0] q);
      if (is_nan(p) || is_nan(q)) return 0;
      if (((p | q) & 32'h7FFFFFFF) == 0) return 1;
      return p == q;
   endfunction

   function bit less(logic [31:0] p, logic [31:0] q);
      if (is_nan(p) || is_nan(q)) return 0;
      if (((p | q) & 32'h7FFFFFFF) == 0) return 0;
      if (p[31] != q[31]) return p[31];
      if (!p[31]) return p < q;
      return p > q;
   endfunction

   // Notes one accepted word and queues the response it must produce.
   function void note_vertex(logic [31:0] v [3]);
      lookup_result r;
      bit hit;
      hit = 0;
      r.index = 0;
      r.was_new = 0;
      r.full = 0;
      for (int i = 0; i < fill && !hit; i++) begin
         if (same(cells[i][0], v[0]) && same(cells[i][1], v[1]) &&
             same(cells[i][2], v[2])) begin
            hit = 1;
            r.index = i[7:0];
         end
      end
      if (!hit) begin
         if (fill >= 256) begin
            r.full = 1;
         end else begin
            r.index = fill[7:0];
            r.was_new = 1;
            for (int a = 0; a < 3; a++) begin
               cells[fill][a] = v[a];
               if (fill == 0) begin
                  box_lo[a] = v[a];
                  box_hi[a] = v[a];
               end else begin
                  if (less(v[a], box_lo[a])) box_lo[a] = v[a];
                  if (less(box_hi[a], v[a])) box_hi[a] = v[a];
               end
            end
            fill++;
         end
      end
      r.lo = box_lo;
      r.hi = box_hi;
      owed.push_back(r);
   endfunction

   function void field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Compares one accepted response against the oldest one owed.
   function void check_response(logic [7:0] index, logic was_new, logic full,
                                logic [31:0] lo [3], logic [31:0] hi [3]);
      lookup_result r;
      if (owed.size() == 0) begin
         $display("%0t unexpected response index %h", $time, index);
         errors++;
         return;
      end
      r = owed.pop_front();
      field("vertex_index", r.index, index);
      field("was_new", r.was_new, was_new);
      field("table_full", r.full, full);
      for (int a = 0; a < 3; a++) begin
         field("box_min", r.lo[a], lo[a]);
         field("box_max", r.hi[a], hi[a]);
      end
   endfunction
endclass

module vertex_dedup_with_bounds_tb;
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_vertex_x, req_vertex_y, req_vertex_z;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_vertex_index;
   logic        rsp_was_new, rsp_table_full;
   logic [31:0] rsp_box_min_x, rsp_box_min_y, rsp_box_min_z;
   logic [31:0] rsp_box_max_x, rsp_box_max_y, rsp_box_max_z;

   vertex_dedup_with_bounds uut (.*);

   dedup_scoreboard board;

   // Idling is switched off for the last stretch of the run.
   bit          calm;
   int unsigned stall_left;
   int unsigned quiet_cycles;
   logic [31:0] pool [$];   // earlier coordinates, replayed to force hits

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver: ready drops in random bursts.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready <= 1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready <= 0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1;
      end
   end

   // Responses are sampled at the edge, so values are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_vertex_index, rsp_was_new, rsp_table_full,
                              '{rsp_box_min_x, rsp_box_min_y, rsp_box_min_z},
                              '{rsp_box_max_x, rsp_box_max_y, rsp_box_max_z});
   end

   // Watchdog: a long spell with no word moving on either channel is a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 2000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Sends one word and holds it until the block takes it. Valid stays high
   // after the accept so that a following word can go out back to back; it
   // is dropped only when the sender idles.
   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1;
      req_vertex_x <= x;
      req_vertex_y <= y;
      req_vertex_z <= z;
      do @(posedge clock); while (!req_ready);
      board.note_vertex('{x, y, z});
      pool.push_back(x);
      pool.push_back(y);
      pool.push_back(z);
      if (pool.size() > 60) void'(pool.pop_front());
   endtask

   function automatic logic [31:0] pick_float();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'h0};
         3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF,
                    23'($urandom_range(1, 32'h7FFFFF))};
         4, 5: return pool.size() ? pool[$urandom_range(0, pool.size() - 1)]
                                  : $urandom();
         6: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 8))};
         default: return $urandom();
      endcase
   endfunction

   task automatic wait_drained();
      req_valid <= 0;
      while (board.owed.size() != 0) @(posedge clock);
   endtask

   initial begin
      board = new();
      board.clear();
      calm = 0;
      reset <= 1;
      req_valid <= 0;
      req_vertex_x <= 0;
      req_vertex_y <= 0;
      req_vertex_z <= 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: a NaN first vertex sets the box to the NaN pattern, which then
      // stays on that axis; signed zeros match each other and keep their sign.
      send_vertex(32'h7FC0_0000, 32'h8000_0000, 32'h0000_0000);
      send_vertex(32'h7FC0_0000, 32'h8000_0000, 32'h0000_0000);
      send_vertex(32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vertex(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'hFF80_0000, 32'h7F80_0000, 32'hFFFF_FFFF);
      send_vertex(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001);
      send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_vertex(32'h8000_0001, 32'h3F80_0000, 32'hBF80_0000);
      send_vertex(32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0001);
      send_vertex(32'hFF80_0000, 32'h7F80_0000, 32'hFFFF_FFFF);
      send_vertex(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001);

      // Hold off until the block has answered everything so far.
      wait_drained();

      // Random part: fills the table past capacity, so later misses report
      // full while repeats of stored vertices still hit.
      for (int n = 0; n < 940; n++) begin
         if (n == 880) calm = 1;
         if (n == 500) wait_drained();
         send_vertex(pick_float(), pick_float(), pick_float());
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

@@ vertex_dedup_with_bounds.f @@
sv/vdb_pkg.sv
sv/vdb_cell.sv
sv/vdb_prio.sv
sv/vertex_dedup_with_bounds.sv
dv/vertex_dedup_with_bounds_tb.sv
